// ===== rtl/i2c_eeb_pkg.sv =====
// ----------------------------------------------------------------------------
// i2c_eeb_pkg
// Types, codes and sequence tables shared by the EEPROM byte access master.
// ----------------------------------------------------------------------------
package i2c_eeb_pkg;

    localparam int PHASE_W = 8;
    localparam int WAIT_W  = 20;

    localparam int SCL_IDX = 0;
    localparam int SDA_IDX = 1;

    localparam logic CFG_PHASE = 1'b0;
    localparam logic CFG_WAIT  = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BUS_BUSY = 2'd1;
    localparam logic [1:0] ST_BUS_ERR  = 2'd2;
    localparam logic [1:0] ST_NACK     = 2'd3;

    localparam logic [3:0] PC_FIRST     = 4'd1;
    localparam logic [3:0] PC_NACK_STOP = 4'd13;

    localparam logic [7:0] CTRL_BASE = 8'hA0;
    localparam logic [7:0] ADDR8_BIT = 8'h02;
    localparam logic [7:0] WR_MASK   = 8'hFE;
    localparam logic [7:0] RD_BIT    = 8'h01;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    typedef enum logic [3:0] {
        K_IDLE, K_START, K_RSTART, K_SEND_CW, K_SEND_AD, K_SEND_DA, K_SEND_CR,
        K_ACKDEV, K_ACK, K_RECV, K_NOACK, K_STOP, K_WAIT, K_DONE_OK, K_DONE_NACK
    } kind_t;

    typedef struct packed {
        logic       scl_low;
        logic       sda_low;
        logic       busy_res;
        logic       done_res;
        logic [1:0] status;
        logic [7:0] read_data;
    } res_t;

    // step program: op 0 byte write, op 1 random read
    function automatic kind_t kind_of(input logic op, input logic [3:0] pc);
        kind_t k;
        k = K_DONE_OK;
        case (pc)
            4'd0:  k = K_IDLE;
            4'd1:  k = K_START;
            4'd2:  k = K_SEND_CW;
            4'd3:  k = K_ACKDEV;
            4'd4:  k = K_SEND_AD;
            4'd5:  k = K_ACK;
            4'd6:  k = op ? K_RSTART  : K_SEND_DA;
            4'd7:  k = op ? K_SEND_CR : K_ACK;
            4'd8:  k = op ? K_ACK     : K_STOP;
            4'd9:  k = op ? K_RECV    : K_WAIT;
            4'd10: k = op ? K_NOACK   : K_DONE_OK;
            4'd11: k = op ? K_STOP    : K_DONE_OK;
            4'd12: k = K_DONE_OK;
            4'd13: k = K_STOP;
            4'd14: k = K_DONE_NACK;
            default: k = K_DONE_OK;
        endcase
        return k;
    endfunction

    function automatic logic is_send(input kind_t k);
        return (k == K_SEND_CW) || (k == K_SEND_AD) || (k == K_SEND_DA) ||
               (k == K_SEND_CR);
    endfunction

    // line drive on entry to a sub phase; bit 0 SCL low, bit 1 SDA low
    function automatic logic [1:0] apply_entry(input kind_t k, input logic [1:0] sub,
                                               input logic [1:0] drv, input logic msb);
        logic [1:0] d;
        d = drv;
        case (k)
            K_START, K_RSTART: begin
                case (sub)
                    2'd0:    d = 2'b00;
                    2'd1:    d[SDA_IDX] = 1'b1;
                    default: d[SCL_IDX] = 1'b1;
                endcase
            end
            K_SEND_CW, K_SEND_AD, K_SEND_DA, K_SEND_CR: begin
                case (sub)
                    2'd0:    d[SCL_IDX] = 1'b1;
                    2'd1:    d[SDA_IDX] = ~msb;
                    default: d[SCL_IDX] = 1'b0;
                endcase
            end
            K_ACKDEV, K_ACK, K_NOACK: begin
                case (sub)
                    2'd0, 2'd3: d[SCL_IDX] = 1'b1;
                    2'd1:       d[SDA_IDX] = 1'b0;
                    default:    d[SCL_IDX] = 1'b0;
                endcase
            end
            K_RECV: begin
                case (sub)
                    2'd0:    d = 2'b01;
                    default: d[SCL_IDX] = 1'b0;
                endcase
            end
            K_STOP: begin
                case (sub)
                    2'd0:    d = 2'b11;
                    2'd1:    d[SCL_IDX] = 1'b0;
                    default: d[SDA_IDX] = 1'b0;
                endcase
            end
            default: d = drv;
        endcase
        return d;
    endfunction

endpackage

// ===== rtl/i2c_eeb_seq.sv =====
// ----------------------------------------------------------------------------
// i2c_eeb_seq
// Bus sequencer: holds the access state and advances it by one tick per word.
// ----------------------------------------------------------------------------
module i2c_eeb_seq
    import i2c_eeb_pkg::*;
#(
    parameter int TIMER_BITS = 20
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  logic                 start_req,
    input  logic                 req_type,
    input  logic [8:0]           mem_address,
    input  logic [7:0]           write_data,
    input  logic                 sda_level,
    input  logic [PHASE_W-1:0]   phase_ticks,
    input  logic [WAIT_W-1:0]    write_wait_ticks,
    output res_t                 res
);

    logic [3:0]            pc_reg, pc_next;
    logic [1:0]            sub_reg, sub_next;
    logic [3:0]            bit_reg, bit_next;
    logic [7:0]            shift_reg, shift_next;
    logic [TIMER_BITS-1:0] tick_reg, tick_next;
    logic [8:0]            addr_reg, addr_next;
    logic [7:0]            data_reg, data_next;
    logic                  op_reg, op_next;
    logic [7:0]            read_reg, read_next;
    logic [1:0]            status_reg, status_next;
    logic [1:0]            drive_reg, drive_next;

    logic [TIMER_BITS+WAIT_W-1:0]  wait_wide;
    logic [TIMER_BITS+PHASE_W-1:0] phase_wide;
    logic [TIMER_BITS-1:0]         wait_lim;
    logic [TIMER_BITS-1:0]         phase_lim;
    logic [PHASE_W-1:0]            phase_eff;

    always_comb begin
        phase_eff  = (phase_ticks == '0) ? PHASE_W'(1) : phase_ticks;
        wait_wide  = {{TIMER_BITS{1'b0}}, write_wait_ticks};
        phase_wide = {{TIMER_BITS{1'b0}}, phase_eff};
        wait_lim   = wait_wide[TIMER_BITS-1:0];
        phase_lim  = phase_wide[TIMER_BITS-1:0];
    end

    kind_t                 k_cur;
    kind_t                 k_ent;
    logic                  idle;
    logic                  do_enter;
    logic                  do_fin;
    logic                  fin_done;
    logic [3:0]            enter_pc;
    logic [1:0]            fin_status;
    logic [TIMER_BITS-1:0] tick_inc;
    logic [TIMER_BITS-1:0] lim;
    logic [7:0]            ctrl;
    logic                  busy;

    always_comb begin
        pc_next     = pc_reg;
        sub_next    = sub_reg;
        bit_next    = bit_reg;
        shift_next  = shift_reg;
        tick_next   = tick_reg;
        read_next   = read_reg;
        status_next = status_reg;
        drive_next  = drive_reg;
        do_enter    = 1'b0;
        do_fin      = 1'b0;
        enter_pc    = pc_reg + 4'd1;
        fin_status  = ST_OK;
        k_ent       = K_IDLE;
        idle        = (pc_reg == 4'd0);

        if (idle && start_req) begin
            op_next   = req_type;
            addr_next = mem_address;
            data_next = write_data;
        end else begin
            op_next   = op_reg;
            addr_next = addr_reg;
            data_next = data_reg;
        end
        ctrl = CTRL_BASE | ({7'd0, addr_next[8]} << 1 & ADDR8_BIT);

        k_cur    = kind_of(op_reg, pc_reg);
        lim      = (k_cur == K_WAIT) ? wait_lim : phase_lim;
        tick_inc = tick_reg + TIMER_BITS'(1);

        if (idle) begin
            if (start_req) begin
                do_enter = 1'b1;
                enter_pc = PC_FIRST;
            end
        end else begin
            tick_next = tick_inc;
            if (tick_inc >= lim) begin
                if (k_cur == K_START || k_cur == K_RSTART) begin
                    if (sub_reg == 2'd0 && !sda_level) begin
                        if (k_cur == K_START) begin
                            do_fin     = 1'b1;
                            fin_status = ST_BUS_BUSY;
                        end else begin
                            do_enter = 1'b1;
                        end
                    end else if (sub_reg == 2'd1 && sda_level) begin
                        if (k_cur == K_START) begin
                            do_fin     = 1'b1;
                            fin_status = ST_BUS_ERR;
                        end else begin
                            do_enter = 1'b1;
                        end
                    end else if (sub_reg < 2'd2) begin
                        sub_next   = sub_reg + 2'd1;
                        tick_next  = '0;
                        drive_next = apply_entry(k_cur, sub_next, drive_reg, shift_reg[7]);
                    end else begin
                        do_enter = 1'b1;
                    end
                end else if (is_send(k_cur)) begin
                    if (sub_reg < 2'd2) begin
                        sub_next   = sub_reg + 2'd1;
                        tick_next  = '0;
                        drive_next = apply_entry(k_cur, sub_next, drive_reg, shift_reg[7]);
                    end else begin
                        shift_next = {shift_reg[6:0], 1'b0};
                        bit_next   = bit_reg + 4'd1;
                        if (bit_next >= BITS_PER_BYTE) begin
                            drive_next[SCL_IDX] = 1'b1;
                            do_enter            = 1'b1;
                        end else begin
                            sub_next   = 2'd0;
                            tick_next  = '0;
                            drive_next = apply_entry(k_cur, 2'd0, drive_reg, shift_next[7]);
                        end
                    end
                end else if (k_cur == K_ACKDEV || k_cur == K_ACK) begin
                    if (sub_reg < 2'd2) begin
                        sub_next   = sub_reg + 2'd1;
                        tick_next  = '0;
                        drive_next = apply_entry(k_cur, sub_next, drive_reg, shift_reg[7]);
                    end else begin
                        drive_next[SCL_IDX] = 1'b1;
                        do_enter            = 1'b1;
                        if (k_cur == K_ACKDEV && sda_level) begin
                            enter_pc = PC_NACK_STOP;
                        end
                    end
                end else if (k_cur == K_RECV) begin
                    if (sub_reg == 2'd0) begin
                        sub_next   = 2'd1;
                        tick_next  = '0;
                        drive_next = apply_entry(k_cur, 2'd1, drive_reg, shift_reg[7]);
                    end else begin
                        shift_next = {shift_reg[6:0], sda_level};
                        bit_next   = bit_reg + 4'd1;
                        if (bit_next >= BITS_PER_BYTE) begin
                            drive_next[SCL_IDX] = 1'b1;
                            do_enter            = 1'b1;
                        end else begin
                            sub_next   = 2'd0;
                            tick_next  = '0;
                            drive_next = apply_entry(k_cur, 2'd0, drive_reg, shift_next[7]);
                        end
                    end
                end else if (k_cur == K_NOACK) begin
                    if (sub_reg < 2'd3) begin
                        sub_next   = sub_reg + 2'd1;
                        tick_next  = '0;
                        drive_next = apply_entry(k_cur, sub_next, drive_reg, shift_reg[7]);
                    end else begin
                        do_enter = 1'b1;
                    end
                end else if (k_cur == K_STOP) begin
                    if (sub_reg < 2'd2) begin
                        sub_next   = sub_reg + 2'd1;
                        tick_next  = '0;
                        drive_next = apply_entry(k_cur, sub_next, drive_reg, shift_reg[7]);
                    end else begin
                        do_enter = 1'b1;
                    end
                end else begin
                    do_enter = 1'b1;
                end
            end
        end

        if (do_enter) begin
            k_ent = kind_of(op_next, enter_pc);
            // zero write wait falls straight through to the next step
            if (k_ent == K_WAIT && wait_lim == '0) begin
                enter_pc = enter_pc + 4'd1;
                k_ent    = kind_of(op_next, enter_pc);
            end
            pc_next   = enter_pc;
            sub_next  = 2'd0;
            tick_next = '0;
            bit_next  = 4'd0;
            case (k_ent)
                K_SEND_CW: shift_next = ctrl & WR_MASK;
                K_SEND_CR: shift_next = (ctrl & WR_MASK) | RD_BIT;
                K_SEND_AD: shift_next = addr_next[7:0];
                K_SEND_DA: shift_next = data_next;
                K_RECV:    shift_next = 8'd0;
                default:   shift_next = shift_next;
            endcase
            case (k_ent)
                K_DONE_OK: begin
                    if (op_next) begin
                        read_next = shift_next;
                    end
                    do_fin     = 1'b1;
                    fin_status = ST_OK;
                end
                K_DONE_NACK: begin
                    do_fin     = 1'b1;
                    fin_status = ST_NACK;
                end
                K_IDLE: begin
                    do_fin     = 1'b1;
                    fin_status = ST_OK;
                end
                default: drive_next = apply_entry(k_ent, 2'd0, drive_next, shift_next[7]);
            endcase
        end

        fin_done = do_fin;
        if (do_fin) begin
            status_next = fin_status;
            pc_next     = 4'd0;
            sub_next    = 2'd0;
            tick_next   = '0;
            drive_next  = 2'b00;
        end

        busy = idle ? start_req : !fin_done;

        res.scl_low   = drive_reg[SCL_IDX];
        res.sda_low   = drive_reg[SDA_IDX];
        res.busy_res  = busy;
        res.done_res  = fin_done;
        res.status    = status_next;
        res.read_data = read_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg     <= 4'd0;
            sub_reg    <= 2'd0;
            bit_reg    <= 4'd0;
            shift_reg  <= 8'd0;
            tick_reg   <= '0;
            addr_reg   <= 9'd0;
            data_reg   <= 8'd0;
            op_reg     <= 1'b0;
            read_reg   <= 8'd0;
            status_reg <= ST_OK;
            drive_reg  <= 2'b00;
        end else if (step) begin
            pc_reg     <= pc_next;
            sub_reg    <= sub_next;
            bit_reg    <= bit_next;
            shift_reg  <= shift_next;
            tick_reg   <= tick_next;
            addr_reg   <= addr_next;
            data_reg   <= data_next;
            op_reg     <= op_next;
            read_reg   <= read_next;
            status_reg <= status_next;
            drive_reg  <= drive_next;
        end
    end

    a_idle_released: assert property (@(posedge aclk) disable iff (!aresetn)
        (pc_reg == 4'd0) |-> (sub_reg == 2'd0 && drive_reg == 2'b00))
        else $error("idle sequencer drives the bus");

    a_done_goes_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && res.done_res) |=> (pc_reg == 4'd0 && drive_reg == 2'b00))
        else $error("finished access did not return to idle");

    a_bit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        bit_reg < BITS_PER_BYTE)
        else $error("bit counter beyond one byte");

    a_hold_when_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        !step |=> ($stable(pc_reg) && $stable(tick_reg) && $stable(drive_reg)))
        else $error("sequencer moved without a tick");

endmodule

// ===== rtl/i2c_eeprom_byte_access_master_unit.sv =====
// ----------------------------------------------------------------------------
// i2c_eeprom_byte_access_master_unit
// Open-drain I2C master for byte write and random byte read of a 512-byte
// EEPROM. Each input word is one bus tick; each tick yields one output word.
//
//   channel  direction  contents
//   s_       in         tick: start request, type, address, data, SDA sample
//   m_       out        line drive, busy, done, status, last read byte
//   cfg_     in         phase_ticks (index 0), write_wait_ticks (index 1)
//
// One word per cycle while s_tready is high; a tick's result is registered on acceptance.
// The sequencer state and the output register both advance on s_ acceptance.
// s_tready is low only while an output word waits and m_tready is low.
// Synchronous active-low reset: bus released, status ok, read byte zero.
// ----------------------------------------------------------------------------
module i2c_eeprom_byte_access_master_unit
    import i2c_eeb_pkg::*;
#(
    parameter int TIMER_BITS = 20
) (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [23:0]         s_tdata,   // start_req, mem_address[8:0], write_data[7:0],
                                           // sda_level, zero pad
    input  logic                s_tuser,   // req_type

    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [15:0]         m_tdata,   // scl_low, sda_low, busy_res, done_res,
                                           // status[1:0], read_data[7:0], zero pad

    input  logic                cfg_wr_en,
    input  logic                cfg_index,
    input  logic [WAIT_W-1:0]   cfg_wdata
);

    logic [PHASE_W-1:0] phase_reg;
    logic [WAIT_W-1:0]  wait_reg;
    logic               m_valid_reg, m_valid_next;
    res_t               res;
    res_t               res_reg;
    logic               step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PHASE_W'(10);
            wait_reg  <= WAIT_W'(12000);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_PHASE: phase_reg <= cfg_wdata[PHASE_W-1:0];
                CFG_WAIT:  wait_reg  <= cfg_wdata;
                default:   wait_reg  <= wait_reg;
            endcase
        end
    end

    assign s_tready = !m_valid_reg || m_tready;
    assign step     = s_tvalid && s_tready;

    i2c_eeb_seq #(
        .TIMER_BITS (TIMER_BITS)
    ) u_seq (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .step             (step),
        .start_req        (s_tdata[0]),
        .req_type         (s_tuser),
        .mem_address      (s_tdata[9:1]),
        .write_data       (s_tdata[17:10]),
        .sda_level        (s_tdata[18]),
        .phase_ticks      (phase_reg),
        .write_wait_ticks (wait_reg),
        .res              (res)
    );

    always_comb begin
        if (step) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, res_reg.read_data, res_reg.status, res_reg.done_res,
                       res_reg.busy_res, res_reg.sda_low, res_reg.scl_low};

    a_word_out: assert property (@(posedge aclk) disable iff (!aresetn)
        step |=> m_valid_reg)
        else $error("accepted tick produced no output word");

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |-> !step)
        else $error("tick accepted over a pending output word");

    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(res_reg.done_res && res_reg.busy_res))
        else $error("done and busy in the same word");

endmodule

// ===== tb/i2c_eeb_tick_sb_pkg.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// i2c_eeb_tick_sb_pkg
// Tick-accurate predictor and output checker for the EEPROM byte access
// master. Every accepted input word advances a private copy of the bus
// sequencer. The expected output word is queued and compared with the next
// word taken from the block.
// ----------------------------------------------------------------------------
package i2c_eeb_tick_sb_pkg;
    import i2c_eeb_pkg::*;

    // step scripts, pc 15 down to pc 0
    localparam logic [63:0] WRITE_SCRIPT = {
        K_DONE_OK, K_DONE_NACK, K_STOP, K_DONE_OK, K_DONE_OK, K_DONE_OK, K_WAIT, K_STOP,
        K_ACK, K_SEND_DA, K_ACK, K_SEND_AD, K_ACKDEV, K_SEND_CW, K_START, K_IDLE
    };
    localparam logic [63:0] READ_SCRIPT = {
        K_DONE_OK, K_DONE_NACK, K_STOP, K_DONE_OK, K_STOP, K_NOACK, K_RECV, K_ACK,
        K_SEND_CR, K_RSTART, K_ACK, K_SEND_AD, K_ACKDEV, K_SEND_CW, K_START, K_IDLE
    };

    // output word, m_tdata[13:0]
    typedef struct packed {
        logic [7:0] rdata;
        logic [1:0] status;
        logic       done;
        logic       busy;
        logic       sda;
        logic       scl;
    } bus_word_t;

    class eeprom_bus_predictor;
        logic [7:0]  phase_len;
        logic [19:0] wait_len;
        logic [3:0]  pc;
        logic [1:0]  sub;
        logic [3:0]  bit_cnt;
        logic [7:0]  shreg;
        logic [19:0] ticks;
        logic [8:0]  addr;
        logic [7:0]  wdata;
        logic        op;
        logic [7:0]  rd_last;
        logic [1:0]  st_last;
        logic [1:0]  drv;
        logic        ended;
        bus_word_t   words_due[$];
        int unsigned errors;

        function new();
            phase_len = 8'd10;
            wait_len  = 20'd12000;
            pc        = 4'd0;
            sub       = 2'd0;
            bit_cnt   = 4'd0;
            shreg     = 8'h00;
            ticks     = 20'd0;
            addr      = 9'd0;
            wdata     = 8'h00;
            op        = 1'b0;
            rd_last   = 8'h00;
            st_last   = ST_OK;
            drv       = 2'b00;
            ended     = 1'b0;
            errors    = 0;
        endfunction

        function void set_reg(logic idx, logic [19:0] v);
            if (idx == CFG_PHASE) begin
                phase_len = v[7:0];
            end else begin
                wait_len = v;
            end
        endfunction

        function kind_t kind_at(logic [3:0] p);
            logic [63:0] script;
            script = op ? READ_SCRIPT : WRITE_SCRIPT;
            return kind_t'(script[{p, 2'b00} +: 4]);
        endfunction

        function void drive_entry(kind_t k, logic [1:0] s);
            case (k)
                K_START, K_RSTART: begin
                    if (s == 2'd0) drv = 2'b00;
                    else if (s == 2'd1) drv[SDA_IDX] = 1'b1;
                    else drv[SCL_IDX] = 1'b1;
                end
                K_SEND_CW, K_SEND_AD, K_SEND_DA, K_SEND_CR: begin
                    if (s == 2'd0) drv[SCL_IDX] = 1'b1;
                    else if (s == 2'd1) drv[SDA_IDX] = ~shreg[7];
                    else drv[SCL_IDX] = 1'b0;
                end
                K_ACKDEV, K_ACK, K_NOACK: begin
                    if (s == 2'd0 || s == 2'd3) drv[SCL_IDX] = 1'b1;
                    else if (s == 2'd1) drv[SDA_IDX] = 1'b0;
                    else drv[SCL_IDX] = 1'b0;
                end
                K_RECV: begin
                    if (s == 2'd0) begin
                        drv = 2'b00;
                        drv[SCL_IDX] = 1'b1;
                    end else begin
                        drv[SCL_IDX] = 1'b0;
                    end
                end
                K_STOP: begin
                    if (s == 2'd0) drv = 2'b11;
                    else if (s == 2'd1) drv[SCL_IDX] = 1'b0;
                    else drv[SDA_IDX] = 1'b0;
                end
                default: ;
            endcase
        endfunction

        function void close_access(logic [1:0] st);
            st_last = st;
            pc      = 4'd0;
            sub     = 2'd0;
            ticks   = 20'd0;
            drv     = 2'b00;
            ended   = 1'b1;
        endfunction

        function void set_sub(kind_t k, logic [1:0] s);
            sub   = s;
            ticks = 20'd0;
            drive_entry(k, s);
        endfunction

        function void enter_step(logic [3:0] p);
            kind_t      k;
            logic [7:0] ctrl;
            k = kind_at(p);
            // no write cycle wait: straight to the finish
            if (k == K_WAIT && wait_len == 20'd0) begin
                p = p + 4'd1;
                k = kind_at(p);
            end
            pc      = p;
            sub     = 2'd0;
            ticks   = 20'd0;
            bit_cnt = 4'd0;
            ctrl    = CTRL_BASE | (addr[8] ? ADDR8_BIT : 8'h00);
            case (k)
                K_SEND_CW: shreg = ctrl & WR_MASK;
                K_SEND_CR: shreg = (ctrl & WR_MASK) | RD_BIT;
                K_SEND_AD: shreg = addr[7:0];
                K_SEND_DA: shreg = wdata;
                K_RECV:    shreg = 8'h00;
                K_DONE_OK: begin
                    if (op) rd_last = shreg;
                    close_access(ST_OK);
                    return;
                end
                K_DONE_NACK: begin
                    close_access(ST_NACK);
                    return;
                end
                K_IDLE: begin
                    close_access(ST_OK);
                    return;
                end
                default: ;
            endcase
            drive_entry(k, 2'd0);
        endfunction

        function void end_phase(logic sda);
            kind_t k;
            k = kind_at(pc);
            case (k)
                K_START, K_RSTART: begin
                    if ((sub == 2'd0 && !sda) || (sub == 2'd1 && sda)) begin
                        // a failed repeated start just moves on
                        if (k == K_START) close_access(sub == 2'd0 ? ST_BUS_BUSY : ST_BUS_ERR);
                        else enter_step(pc + 4'd1);
                    end else if (sub < 2'd2) begin
                        set_sub(k, sub + 2'd1);
                    end else begin
                        enter_step(pc + 4'd1);
                    end
                end
                K_SEND_CW, K_SEND_AD, K_SEND_DA, K_SEND_CR: begin
                    if (sub < 2'd2) begin
                        set_sub(k, sub + 2'd1);
                    end else begin
                        shreg   = shreg << 1;
                        bit_cnt = bit_cnt + 4'd1;
                        if (bit_cnt >= BITS_PER_BYTE) begin
                            drv[SCL_IDX] = 1'b1;
                            enter_step(pc + 4'd1);
                        end else begin
                            set_sub(k, 2'd0);
                        end
                    end
                end
                K_ACKDEV, K_ACK: begin
                    if (sub < 2'd2) begin
                        set_sub(k, sub + 2'd1);
                    end else begin
                        drv[SCL_IDX] = 1'b1;
                        if (k == K_ACKDEV && sda) enter_step(PC_NACK_STOP);
                        else enter_step(pc + 4'd1);
                    end
                end
                K_RECV: begin
                    if (sub == 2'd0) begin
                        set_sub(k, 2'd1);
                    end else begin
                        shreg   = {shreg[6:0], sda};
                        bit_cnt = bit_cnt + 4'd1;
                        if (bit_cnt >= BITS_PER_BYTE) begin
                            drv[SCL_IDX] = 1'b1;
                            enter_step(pc + 4'd1);
                        end else begin
                            set_sub(k, 2'd0);
                        end
                    end
                end
                K_NOACK: begin
                    if (sub < 2'd3) set_sub(k, sub + 2'd1);
                    else enter_step(pc + 4'd1);
                end
                K_STOP: begin
                    if (sub < 2'd2) set_sub(k, sub + 2'd1);
                    else enter_step(pc + 4'd1);
                end
                default: enter_step(pc + 4'd1);
            endcase
        endfunction

        function void note_tick(logic req, logic typ, logic [8:0] a, logic [7:0] d, logic sda);
            bus_word_t   w;
            kind_t       k;
            logic [19:0] lim;
            w.scl = drv[SCL_IDX];
            w.sda = drv[SDA_IDX];
            ended = 1'b0;
            if (pc == 4'd0) begin
                w.busy = 1'b0;
                if (req) begin
                    op    = typ;
                    addr  = a;
                    wdata = d;
                    enter_step(PC_FIRST);
                    w.busy = 1'b1;
                end
            end else begin
                k = kind_at(pc);
                if (k == K_WAIT) lim = wait_len;
                else lim = (phase_len == 8'd0) ? 20'd1 : {12'd0, phase_len};
                ticks = ticks + 20'd1;
                if (ticks >= lim) end_phase(sda);
                w.busy = ~ended;
            end
            w.done   = ended;
            w.status = st_last;
            w.rdata  = rd_last;
            words_due.push_back(w);
        endfunction

        function void check_word(logic [15:0] raw);
            bus_word_t got;
            bus_word_t want;
            got = bus_word_t'(raw[13:0]);
            if (words_due.size() == 0) begin
                errors++;
                if (errors <= 10) $display("output word %h with nothing due", raw);
                return;
            end
            want = words_due.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10) begin
                    $display("word mismatch (exp/act): scl %b/%b sda %b/%b busy %b/%b done %b/%b",
                             want.scl, got.scl, want.sda, got.sda, want.busy, got.busy,
                             want.done, got.done);
                    $display("    status %0d/%0d read_data %h/%h",
                             want.status, got.status, want.rdata, got.rdata);
                end
            end
        endfunction
    endclass

endpackage

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Bench for the EEPROM byte access master. A small device model answers on
// SDA from the predicted bus state, with faults injected per access: bus
// busy, bus error, device nack, broken repeated start and line noise.
// Directed accesses cover the field and register extremes, then random
// accesses run over several phase and write wait settings with random
// sender bursts, receiver stalls and one long output hold per setting.
// ----------------------------------------------------------------------------
module tb;
    import i2c_eeb_pkg::*;
    import i2c_eeb_tick_sb_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200_000;
    localparam int TICK_BUDGET   = 1950;
    localparam int CONFIG_ROUNDS = 3;
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef enum logic [2:0] {
        F_NONE, F_BUS_BUSY, F_BUS_ERR, F_DEV_NACK, F_RS_LOW, F_RS_HIGH, F_NOISE
    } fault_t;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [23:0]       s_tdata   = '0;
    logic              s_tuser   = 1'b0;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [15:0]       m_tdata;
    logic              cfg_wr_en = 1'b0;
    logic              cfg_index = 1'b0;
    logic [WAIT_W-1:0] cfg_wdata = '0;

    eeprom_bus_predictor bus_pred;
    fault_t              fault       = F_NONE;
    logic [7:0]          eeprom_byte = 8'h00;
    logic                late_nack   = 1'b0;
    logic                hold_req    = 1'b0;
    int                  burst_left  = 0;
    int                  gap_max     = 4;
    int                  tick_total  = 0;
    int unsigned         cycle_count = 0;

    i2c_eeprom_byte_access_master_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // SDA as seen on the wire: master drive plus the device's answer
    function automatic logic bus_sda();
        kind_t k;
        logic  line;
        k    = bus_pred.kind_at(bus_pred.pc);
        line = ~bus_pred.drv[SDA_IDX];
        if (fault == F_NOISE) return 1'($urandom_range(0, 1));
        case (k)
            K_START: begin
                if (bus_pred.sub == 2'd0 && fault == F_BUS_BUSY) line = 1'b0;
                if (bus_pred.sub == 2'd1 && fault == F_BUS_ERR) line = 1'b1;
            end
            K_RSTART: begin
                if (bus_pred.sub == 2'd0 && fault == F_RS_LOW) line = 1'b0;
                if (bus_pred.sub == 2'd1 && fault == F_RS_HIGH) line = 1'b1;
            end
            K_ACKDEV: begin
                if (fault != F_DEV_NACK) line = 1'b0;
            end
            K_ACK: begin
                if (!late_nack) line = 1'b0;
            end
            K_RECV: begin
                line = line & eeprom_byte[3'd7 - bus_pred.bit_cnt[2:0]];
            end
            default: ;
        endcase
        return line;
    endfunction

    function automatic fault_t pick_fault();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return F_NONE;
        if (r < 75) return F_BUS_BUSY;
        if (r < 80) return F_BUS_ERR;
        if (r < 87) return F_DEV_NACK;
        if (r < 90) return F_RS_LOW;
        if (r < 93) return F_RS_HIGH;
        return F_NOISE;
    endfunction

    task automatic pace();
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, gap_max);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 48);
        end
        burst_left--;
    endtask

    task automatic send_tick(input logic req, input logic typ, input logic [8:0] a,
                             input logic [7:0] d);
        logic sda;
        pace();
        sda = bus_sda();
        s_tvalid <= 1'b1;
        s_tuser  <= typ;
        s_tdata  <= {5'd0, sda, d, a, req};
        do @(posedge aclk); while (!s_tready);
        bus_pred.note_tick(req, typ, a, d, sda);
        tick_total++;
    endtask

    task automatic send_noise_tick(input logic req);
        send_tick(req, 1'($urandom_range(0, 1)), 9'($urandom_range(0, 511)),
                  8'($urandom_range(0, 255)));
    endtask

    task automatic run_access(input logic op, input logic [8:0] a, input logic [7:0] d,
                              input logic [7:0] rx, input fault_t f);
        fault       = f;
        eeprom_byte = rx;
        late_nack   = ($urandom_range(0, 3) == 0);
        send_tick(1'b1, op, a, d);
        // requests while busy must be ignored
        while (bus_pred.pc != 4'd0) send_noise_tick($urandom_range(0, 7) == 0);
        repeat ($urandom_range(0, 3)) send_noise_tick(1'b0);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (bus_pred.words_due.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [WAIT_W-1:0] v);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        bus_pred.set_reg(idx, v);
        @(posedge aclk);
    endtask

    task automatic configure(input logic [7:0] ph, input logic [WAIT_W-1:0] ww);
        drain();
        write_reg(CFG_PHASE, {12'd0, ph});
        write_reg(CFG_WAIT, ww);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) bus_pred.check_word(m_tdata);
    end

    initial begin : receiver
        int mode;
        int left;
        int hold;
        mode = 0;
        left = 0;
        hold = 0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold     = 400;
            end
            if (left == 0) begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(50, 500);
            end
            left--;
            if (hold > 0) begin
                m_tready <= 1'b0;
                hold--;
            end else begin
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= ($urandom_range(0, 6) != 0);
                    default: m_tready <= (left % 3 == 0);
                endcase
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("tb failed");
        $finish;
    end

    initial begin : stimulus
        int          round;
        int          stop_at;
        logic [7:0]  ph;
        logic [19:0] ww;
        bus_pred = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // register values after reset
        run_access(OP_WRITE, 9'h155, 8'hA5, 8'h00, F_BUS_ERR);
        run_access(OP_READ, 9'h0AA, 8'h00, 8'h5A, F_BUS_BUSY);

        configure(8'd1, 20'd0);
        run_access(OP_WRITE, 9'h1FF, 8'hFF, 8'h00, F_NONE);
        run_access(OP_READ, 9'h000, 8'hFF, 8'h00, F_NONE);
        run_access(OP_READ, 9'h1FF, 8'h00, 8'hFF, F_NONE);
        run_access(OP_WRITE, 9'h1A5, 8'h5A, 8'h00, F_DEV_NACK);
        run_access(OP_READ, 9'h133, 8'h00, 8'hC3, F_RS_LOW);
        run_access(OP_READ, 9'h0CC, 8'h00, 8'h3C, F_RS_HIGH);

        // zero phase length runs as one tick
        configure(8'd0, 20'd1);
        run_access(OP_WRITE, 9'h1E1, 8'h1E, 8'h00, F_NONE);

        configure(8'd255, 20'hFFFFF);
        run_access(OP_WRITE, 9'h1FF, 8'hFF, 8'h00, F_BUS_BUSY);

        for (round = 0; round < CONFIG_ROUNDS; round++) begin
            ph = 8'($urandom_range(1, 2));
            ww = (round == 0) ? 20'd0 : 20'($urandom_range(1, 40));
            configure(ph, ww);
            gap_max    = (round % 2 == 0) ? 4 : 0;
            burst_left = 0;
            hold_req   = 1'b1;
            stop_at    = tick_total + (TICK_BUDGET - tick_total) / (CONFIG_ROUNDS - round);
            while (tick_total < stop_at) begin
                run_access(1'($urandom_range(0, 1)), 9'($urandom_range(0, 511)),
                           8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           pick_fault());
            end
        end

        drain();
        repeat (16) @(posedge aclk);
        if (bus_pred.errors == 0 && bus_pred.words_due.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/i2c_eeb_pkg.sv
rtl/i2c_eeb_seq.sv
rtl/i2c_eeprom_byte_access_master_unit.sv
tb/i2c_eeb_tick_sb_pkg.sv
tb/tb.sv
